FILE: sv/tthash_pkg.sv
// package for the tagged ttl hash table
// holds the slot row layout, request codes, fixed constants, the sequencer states and the key byte mask function
// no dependencies
package tthash_pkg;

	localparam logic [15:0] EMPTY_TAG    = 16'h0000;
	localparam int          HOME_SHIFT   = 16;
	localparam int          TAG_SHIFT    = 48;
	localparam logic [31:0] TTL_AT_RESET = 32'd300;

	typedef enum logic [1:0] {
		REQ_PUT = 2'd0,
		REQ_GET = 2'd1,
		REQ_DEL = 2'd2,
		REQ_BAD = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_ISSUE,
		ST_PROBE
	} state_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [3:0]  len;
		logic [63:0] key;
		logic [63:0] value;
		logic [63:0] expiry;
	} slot_row_t;

	function automatic logic [63:0] key_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < len) begin
				m[i*8 +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

endpackage

FILE: sv/tthash_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module tthash_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: sv/tagged_ttl_hash_table.sv
// top level of the tagged ttl hash table: request sequencer and slot memory
// depends on tthash_pkg and tthash_ram
//
// One request at a time. A request is taken when start is high and busy is low; its result
// appears on ok and read_value for one cycle with done high, and the receiver cannot stall it.
// A request with a bad key length or an unknown type is answered the cycle after it is taken.
// Otherwise the request passes through ST_ISSUE, then ST_PROBE, which probes 1 to PROBE_LIMIT
// slots, one slot per cycle through the single read port of the slot memory; when SHARDS or
// SLOTS_PER_SHARD is not a power of two, a nibble-serial reduction of the hash in ST_REDUCE
// comes first. After reset the memory is cleared one row a cycle, all SHARDS * SLOTS_PER_SHARD
// rows, with busy high. Configuration writes are always taken.
module tagged_ttl_hash_table #(
	parameter int SHARDS          = 8,
	parameter int SLOTS_PER_SHARD = 1024,
	parameter int PROBE_LIMIT     = 16,
	parameter int KEY_BYTES       = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [63:0] key_hash,
	input  logic [63:0] key_bytes,
	input  logic [3:0]  key_length,
	input  logic [63:0] store_value,
	input  logic [31:0] ttl,
	input  logic [63:0] now_sec,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic        ok,
	output logic [63:0] read_value
);

	import tthash_pkg::*;

	localparam int TOTAL    = SHARDS * SLOTS_PER_SHARD;
	localparam int AW       = $clog2(TOTAL);
	localparam int SHW      = (SHARDS > 1) ? $clog2(SHARDS) : 1;
	localparam int OFW      = $clog2(SLOTS_PER_SHARD);
	localparam int PW       = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam int RW       = ((SHW > OFW) ? SHW : OFW) + 5;
	localparam int RW_BITS  = $bits(slot_row_t);
	localparam bit SH_POW2  = (SHARDS & (SHARDS - 1)) == 0;
	localparam bit SL_POW2  = (SLOTS_PER_SHARD & (SLOTS_PER_SHARD - 1)) == 0;
	localparam bit NEED_RED = !(SH_POW2 && SL_POW2);
	localparam logic [RW-1:0] M_SH = RW'(SHARDS);
	localparam logic [RW-1:0] M_SL = RW'(SLOTS_PER_SHARD);
	localparam logic [PW-1:0] P_LAST = PW'(PROBE_LIMIT - 1);
	localparam logic [OFW-1:0] OFF_LAST = OFW'(SLOTS_PER_SHARD - 1);
	localparam logic [AW-1:0]  CLR_LAST = AW'(TOTAL - 1);

	function automatic logic [RW-1:0] red_step(input logic [RW-1:0] v, input logic [RW-1:0] m);
		logic [RW-1:0] r;
		r = v;
		for (int i = 3; i >= 0; i--) begin
			if (r >= (m << i)) begin
				r = r - (m << i);
			end
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] slot_addr(input logic [SHW-1:0] sh, input logic [OFW-1:0] off);
		return AW'(AW'(sh) * AW'(SLOTS_PER_SHARD) + AW'(off));
	endfunction

	state_t          st_q, st_d;
	logic [AW-1:0]   clr_q;
	logic [3:0]      red_cnt_q;
	logic [RW-1:0]   red_sh_q, red_ho_q;
	logic [1:0]      req_q;
	logic [63:0]     hash_q;
	logic [15:0]     tag_q;
	logic [3:0]      len_q;
	logic [63:0]     key_q, value_q, now_q, exp_q;
	logic [PW-1:0]   p_q;
	logic [OFW-1:0]  off_q, off_d;
	logic [31:0]     default_ttl_q;
	logic            done_q, ok_q;
	logic [63:0]     rv_q;

	logic [SHW-1:0]  shard_w;
	logic [OFW-1:0]  home_w;
	logic [3:0]      nib;
	logic            accept, bad_req;
	logic [15:0]     tag_in;
	logic [31:0]     life;
	logic [64:0]     exp_sum;

	logic            wr_en;
	logic [AW-1:0]   wr_addr, rd_addr;
	slot_row_t       wr_row, rd_row;
	logic [RW_BITS-1:0] rd_raw;

	logic            fin, fin_ok, fin_rv_en, step;
	logic            tag_m, empty, expired, key_m;

	generate
		if (SH_POW2) begin : g_sh_pow2
			assign shard_w = SHW'(hash_q % SHARDS);
		end else begin : g_sh_red
			assign shard_w = SHW'(red_sh_q);
		end
		if (SL_POW2) begin : g_sl_pow2
			assign home_w = hash_q[HOME_SHIFT +: OFW];
		end else begin : g_sl_red
			assign home_w = OFW'(red_ho_q);
		end
	endgenerate

	assign busy      = st_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign bad_req   = req_type == REQ_BAD || key_length == 4'd0 || key_length > 4'(KEY_BYTES);
	assign tag_in    = (key_hash[TAG_SHIFT +: 16] == EMPTY_TAG) ? 16'd1 : key_hash[TAG_SHIFT +: 16];
	assign life      = (ttl != 32'd0) ? ttl : default_ttl_q;
	assign exp_sum   = {1'b0, now_sec} + 65'(life);
	assign nib       = hash_q[(4'd15 - red_cnt_q) * 4 +: 4];

	assign rd_row  = slot_row_t'(rd_raw);
	assign tag_m   = rd_row.tag == tag_q;
	assign empty   = rd_row.tag == EMPTY_TAG;
	assign expired = rd_row.expiry <= now_q;
	assign key_m   = rd_row.len == len_q && rd_row.key == key_q;

	tthash_ram #(
		.WIDTH(RW_BITS),
		.DEPTH(TOTAL)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_row),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	always_comb begin
		st_d      = st_q;
		off_d     = off_q;
		wr_en     = 1'b0;
		wr_addr   = slot_addr(shard_w, off_q);
		wr_row    = '0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_rv_en = 1'b0;
		step      = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == CLR_LAST) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && !bad_req) begin
					st_d = NEED_RED ? ST_REDUCE : ST_ISSUE;
				end
			end
			ST_REDUCE: begin
				if (red_cnt_q == 4'd15) begin
					st_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				off_d = home_w;
				st_d  = ST_PROBE;
			end
			ST_PROBE: begin
				case (req_q)
					REQ_PUT: begin
						if (empty || expired || (tag_m && key_m)) begin
							wr_en      = 1'b1;
							wr_row.tag    = tag_q;
							wr_row.len    = len_q;
							wr_row.key    = key_q;
							wr_row.value  = value_q;
							wr_row.expiry = exp_q;
							fin        = 1'b1;
							fin_ok     = 1'b1;
						end else begin
							step = 1'b1;
						end
					end
					REQ_GET: begin
						if (!tag_m) begin
							if (empty) begin
								fin = 1'b1;
							end else begin
								step = 1'b1;
							end
						end else if (expired) begin
							fin = 1'b1;
						end else if (key_m) begin
							fin       = 1'b1;
							fin_ok    = 1'b1;
							fin_rv_en = 1'b1;
						end else begin
							step = 1'b1;
						end
					end
					REQ_DEL: begin
						if (empty) begin
							fin = 1'b1;
						end else if (tag_m && key_m) begin
							wr_en  = 1'b1;
							fin    = 1'b1;
							fin_ok = 1'b1;
						end else begin
							step = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
				if (step) begin
					if (p_q == P_LAST) begin
						fin = 1'b1;
					end else begin
						off_d = (off_q == OFF_LAST) ? '0 : off_q + 1'b1;
					end
				end
				if (fin) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
		rd_addr = slot_addr(shard_w, off_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_CLEAR;
			clr_q         <= '0;
			default_ttl_q <= TTL_AT_RESET;
			done_q        <= 1'b0;
			ok_q          <= 1'b0;
			rv_q          <= '0;
		end else begin
			st_q   <= st_d;
			done_q <= 1'b0;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				default_ttl_q <= (cfg_data == 32'd0) ? TTL_AT_RESET : cfg_data;
			end
			if (accept && bad_req) begin
				done_q <= 1'b1;
				ok_q   <= 1'b0;
				rv_q   <= '0;
			end
			if (st_q == ST_PROBE && fin) begin
				done_q <= 1'b1;
				ok_q   <= fin_ok;
				rv_q   <= fin_rv_en ? rd_row.value : 64'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			hash_q    <= key_hash;
			tag_q     <= tag_in;
			len_q     <= key_length;
			key_q     <= key_bytes & key_mask(key_length);
			value_q   <= store_value;
			now_q     <= now_sec;
			exp_q     <= exp_sum[64] ? '1 : exp_sum[63:0];
			red_cnt_q <= '0;
			red_sh_q  <= '0;
			red_ho_q  <= '0;
		end
		if (st_q == ST_REDUCE) begin
			red_cnt_q <= red_cnt_q + 1'b1;
			red_sh_q  <= red_step(RW'({red_sh_q, nib}), M_SH);
			if (red_cnt_q < 4'd12) begin
				red_ho_q <= red_step(RW'({red_ho_q, nib}), M_SL);
			end
		end
		if (st_q == ST_ISSUE) begin
			p_q <= '0;
		end else if (st_q == ST_PROBE && step) begin
			p_q <= p_q + 1'b1;
		end
		off_q <= off_d;
	end

	assign done       = done_q;
	assign ok         = ok_q;
	assign read_value = rv_q;

endmodule

FILE: sv/tthash_chk.sv
// port-level checker for the tagged ttl hash table, bound to the top level
// depends only on the top level's ports
module tthash_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        ok,
	input logic [63:0] read_value
);

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither in work nor answered");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (read_value == 64'd0))
		else $error("failed request returned a nonzero value");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result without a request");

endmodule

bind tagged_ttl_hash_table tthash_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.ok        (ok),
	.read_value(read_value)
);
